>>> hw/rtl/puffq_pkg.sv
`timescale 1ns / 1ps

package puffq_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int COUNT_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int MS_BITS       = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_PRESS_THR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_THR = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DUR     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DUR     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PUFFS   = 3'd5;

    localparam logic [SAMPLE_BITS-1:0] RST_PRESS_THR   = SAMPLE_BITS'(2000);
    localparam logic [SAMPLE_BITS-1:0] RST_RELEASE_THR = SAMPLE_BITS'(1500);
    localparam logic [MS_BITS-1:0]     RST_COOLDOWN    = MS_BITS'(1000);
    localparam logic [MS_BITS-1:0]     RST_MIN_DUR     = MS_BITS'(100);
    localparam logic [MS_BITS-1:0]     RST_MAX_DUR     = MS_BITS'(3000);
    localparam logic [MS_BITS-1:0]     RST_MAX_PUFFS   = MS_BITS'(200);

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sensor_sample;
        logic [TIME_BITS-1:0]   now_ms;
    } t_puffq_in;

    typedef struct packed {
        logic                  puff_active;
        logic                  puff_ended;
        logic                  puff_valid;
        logic                  puff_timed_out;
        logic [TIME_BITS-1:0]  puff_duration;
        logic [COUNT_BITS-1:0] total_count;
        logic [COUNT_BITS-1:0] daily_count;
        logic                  limit_reached;
    } t_puffq_out;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] press_threshold;
        logic [SAMPLE_BITS-1:0] release_threshold;
        logic [MS_BITS-1:0]     cooldown_ms;
        logic [MS_BITS-1:0]     min_duration_ms;
        logic [MS_BITS-1:0]     max_duration_ms;
        logic [MS_BITS-1:0]     max_puffs;
    } t_puffq_cfg;

    typedef struct packed {
        logic                  puffing;
        logic [TIME_BITS-1:0]  start_time;
        logic [TIME_BITS-1:0]  last_valid_time;
        logic [COUNT_BITS-1:0] total_puffs;
        logic [COUNT_BITS-1:0] daily_puffs;
    } t_puffq_state;

endpackage

>>> hw/rtl/puffq_cfg_regs.sv
`timescale 1ns / 1ps

module puffq_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [puffq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [puffq_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    output puffq_pkg::t_puffq_cfg               o_cfg
);
    import puffq_pkg::*;

    t_puffq_cfg r_cfg;
    t_puffq_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PRESS_THR:   n_cfg.press_threshold   = i_cfg_data[SAMPLE_BITS-1:0];
                REG_RELEASE_THR: n_cfg.release_threshold = i_cfg_data[SAMPLE_BITS-1:0];
                REG_COOLDOWN:    n_cfg.cooldown_ms       = i_cfg_data[MS_BITS-1:0];
                REG_MIN_DUR:     n_cfg.min_duration_ms   = i_cfg_data[MS_BITS-1:0];
                REG_MAX_DUR:     n_cfg.max_duration_ms   = i_cfg_data[MS_BITS-1:0];
                REG_MAX_PUFFS:   n_cfg.max_puffs         = i_cfg_data[MS_BITS-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_threshold   <= RST_PRESS_THR;
            r_cfg.release_threshold <= RST_RELEASE_THR;
            r_cfg.cooldown_ms       <= RST_COOLDOWN;
            r_cfg.min_duration_ms   <= RST_MIN_DUR;
            r_cfg.max_duration_ms   <= RST_MAX_DUR;
            r_cfg.max_puffs         <= RST_MAX_PUFFS;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hw/rtl/puffq_eval.sv
`timescale 1ns / 1ps

module puffq_eval (
    input  puffq_pkg::t_puffq_in    i_item,
    input  puffq_pkg::t_puffq_state i_state,
    input  puffq_pkg::t_puffq_cfg   i_cfg,
    output puffq_pkg::t_puffq_state o_state,
    output puffq_pkg::t_puffq_out   o_result
);
    import puffq_pkg::*;

    logic                  start;
    logic                  active;
    logic [TIME_BITS-1:0]  begin_ms;
    logic [TIME_BITS-1:0]  since_valid;
    logic [TIME_BITS-1:0]  age;
    logic                  released;
    logic                  valid;
    logic                  held;
    logic                  timed_out;
    logic [COUNT_BITS-1:0] total_next;
    logic [COUNT_BITS-1:0] daily_next;

    always_comb begin
        since_valid = i_item.now_ms - i_state.last_valid_time;
        start       = !i_state.puffing
                      && (i_item.sensor_sample > i_cfg.press_threshold)
                      && (since_valid > TIME_BITS'(i_cfg.cooldown_ms));
        active      = i_state.puffing || start;
        begin_ms    = start ? i_item.now_ms : i_state.start_time;
        age         = i_item.now_ms - begin_ms;

        released    = active && (i_item.sensor_sample < i_cfg.release_threshold);
        valid       = released
                      && (age >= TIME_BITS'(i_cfg.min_duration_ms))
                      && (age <= TIME_BITS'(i_cfg.max_duration_ms));

        held        = active && !released;
        timed_out   = held && (age > TIME_BITS'(i_cfg.max_duration_ms));

        total_next  = i_state.total_puffs;
        daily_next  = i_state.daily_puffs;
        if (valid) begin
            total_next = (i_state.total_puffs == COUNT_MAX) ? COUNT_MAX
                                                            : i_state.total_puffs + 1'b1;
            daily_next = (i_state.daily_puffs == COUNT_MAX) ? COUNT_MAX
                                                            : i_state.daily_puffs + 1'b1;
        end

        o_state.puffing         = held && !timed_out;
        o_state.start_time      = begin_ms;
        o_state.last_valid_time = valid ? i_item.now_ms : i_state.last_valid_time;
        o_state.total_puffs     = total_next;
        o_state.daily_puffs     = daily_next;

        o_result.puff_active    = held && !timed_out;
        o_result.puff_ended     = released;
        o_result.puff_valid     = valid;
        o_result.puff_timed_out = timed_out;
        o_result.puff_duration  = released ? age : '0;
        o_result.total_count    = total_next;
        o_result.daily_count    = daily_next;
        o_result.limit_reached  = valid
                                  && (TIME_BITS'(total_next) >= TIME_BITS'(i_cfg.max_puffs));
    end

endmodule

>>> hw/rtl/puff_event_qualifier_core.sv
// A sample beat enters the input register, then the result register, from which its
// result beat is presented. Throughput: one sample per cycle while the output is not
// stalled; the two registers form a two-entry pipeline, and the puff state is updated
// as a sample moves across. Reset (synchronous, active low): clears the puff state,
// both counters, loads default thresholds, timings and puff limit, empties both registers.
`timescale 1ns / 1ps

module puff_event_qualifier_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  puffq_pkg::t_puffq_in                i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output puffq_pkg::t_puffq_out               o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [puffq_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [puffq_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import puffq_pkg::*;

    t_puffq_cfg   cfg;
    t_puffq_state n_state;
    t_puffq_out   n_out;
    t_puffq_state r_state;
    t_puffq_in    r_in;
    logic         r_in_valid;
    t_puffq_out   r_out;
    logic         r_out_valid;
    logic         advance;

    puffq_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    puffq_eval u_eval (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    assign advance     = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance && r_in_valid) begin
            r_out <= n_out;
        end
    end

    a_counts_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.daily_puffs == r_state.total_puffs)
        else $error("daily and total counts diverged");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_state.total_puffs >= $past(r_state.total_puffs))
        else $error("total count decreased");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_in_valid && r_out_valid && !i_out_ready)
        else $error("input stalled with room in the pipeline");

    a_timeout_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.puff_timed_out |->
            !r_out.puff_active && !r_out.puff_ended && !r_out.puff_valid
            && !r_state.puffing)
        else $error("timed-out beat with puff still live");

endmodule
